// ----- rtl/ffsa_pkg.sv -----
package ffsa_pkg;

	// Command codes on the kind field
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;
	localparam logic [1:0] KIND_REINIT = 2'd3;

	// Result status codes
	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_FAILED  = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_CHK,
		S_A_FIX,
		S_A_WW,
		S_A_WM,
		S_A_WU,
		S_F_CHK,
		S_F_NCHK,
		S_F_NCLR,
		S_F_PREV,
		S_F_PCHK,
		S_F_INS,
		S_F_WALK,
		S_F_CLRU,
		S_F_WU,
		S_F_M,
		S_F_WM,
		S_Q_WALK,
		S_DONE
	} state_t;

endpackage

// ----- rtl/ffsa_hdr_mem.sv -----
// Header store: one write port, one read port, registered read data.
module ffsa_hdr_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 33
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/first_fit_segment_allocator_top.sv -----
// Channel   Handshake            Payload
// in        in_valid/in_ready    kind, request_bytes, payload_offset
// out       out_valid/out_ready  status, granted_offset, alert, rounded_bytes,
//                                free_bytes, largest_free, free_segments
// cfg       cfg_valid/cfg_ready  cfg_data (alert_enable)
//
// One transaction at a time. An allocate walks the free list from the head until a
// segment fits, and fails at once on an empty list; a free reads the freed segment
// and its neighbors, and walks the free list to find the insert point only when the
// freed segment is linked into the list; a query walks the whole list. The header
// memory has one read and one write port.
// Reinitialize clears the header memory, one entry per cycle. After reset the same
// clearing pass runs before in_ready rises; cfg writes are taken at any time.
// in_ready returns in the cycle after the result is loaded.
// The result register lets a new transaction start while the previous result
// still waits on out_ready; a second result stalls in the done state.
module first_fit_segment_allocator_top #(
	parameter int POOL_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] request_bytes,
	input  logic [11:0] payload_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [11:0] granted_offset,
	output logic        alert,
	output logic [16:0] rounded_bytes,
	output logic [12:0] free_bytes,
	output logic [12:0] largest_free,
	output logic [10:0] free_segments,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int POOL_UNITS = (POOL_BYTES + 3) / 4;
	localparam int IW = $clog2(POOL_UNITS);      // unit index / distance
	localparam int LW = $clog2(POOL_UNITS + 1);  // segment length in units
	localparam int HW = 3 * IW + 3;

	// Boundary tag of one unit
	typedef struct packed {
		logic [IW-1:0] prev_d;
		logic [IW-1:0] next_d;
		logic          used;
		logic          start;
		logic [IW-1:0] link;
		logic          link_valid;
	} hdr_t;

	ffsa_pkg::state_t state_q, state_d;

	// Memory port
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic [HW-1:0] rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	hdr_t          wr_data;
	hdr_t          rdata;

	// Control and walk registers
	logic [IW-1:0] cur_q;      // segment under work / walk pointer
	logic [IW-1:0] pred_q;     // list predecessor (alloc) or insert point (free)
	logic          pv_q;       // pred_q is valid
	hdr_t          hu_q;       // header of cur_q being rebuilt
	hdr_t          hpred_q;    // predecessor header, or merged left neighbor
	hdr_t          hn_q;       // right neighbor header
	logic [IW-1:0] n_q;        // right neighbor / follower address
	logic [IW-1:0] p_q;        // left neighbor address
	logic [14:0]   need_q;
	logic          split_q;
	logic [IW-1:0] w_q;
	logic          nfree_q;
	logic          pmerge_q;
	logic [IW-1:0] head_q;
	logic          fhv_q;
	logic          alert_en_q;
	logic [IW-1:0] clr_q;
	logic          reinit_q;

	// Staged result
	logic [1:0]    rs_status_q;
	logic [11:0]   rs_granted_q;
	logic          rs_alert_q;
	logic [16:0]   rs_rounded_q;
	logic [12:0]   fb_q;
	logic [LW+1:0] lg_q;
	logic [10:0]   cnt_q;

	// Output register
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [11:0]   granted_q;
	logic          alert_q;
	logic [16:0]   rounded_q;
	logic [12:0]   free_bytes_q;
	logic [12:0]   largest_q;
	logic [10:0]   segs_q;

	// Combinational helpers
	logic [14:0]   need_c;
	logic [10:0]   fu_c;
	logic          free_ok_c;
	logic          alloc_empty_c;
	logic          free_bad_c;
	logic [LW-1:0] len_c;
	logic [LW+1:0] seg_bytes_c;
	logic          fits_c;
	logic          head_case_c;
	logic          m_needed_c;
	logic [IW-1:0] m_addr_c;
	logic          out_load_c;
	hdr_t          merged_p_c;

	// Header with a new free-list link
	function automatic hdr_t set_link(hdr_t h, logic [IW-1:0] l, logic lv);
		hdr_t r;
		r = h;
		r.link = l;
		r.link_valid = lv;
		return r;
	endfunction

	assign rdata = hdr_t'(rd_data);

	ffsa_hdr_mem #(
		.DEPTH(POOL_UNITS),
		.AW   (IW),
		.W    (HW)
	) u_hdr_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign in_ready  = (state_q == ffsa_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load_c = (state_q == ffsa_pkg::S_DONE) && (!out_valid_q || out_ready);

	// Units needed: round up to whole units plus one header unit; never wraps
	assign need_c = 15'((({1'b0, request_bytes} + 17'd3) >> 2) + 17'd1);
	assign fu_c = {1'b0, payload_offset[11:2]} - 11'd1;
	assign free_ok_c = (payload_offset != 12'd0) && (payload_offset[1:0] == 2'b00) &&
		({21'd0, fu_c} < 32'(POOL_UNITS));
	assign alloc_empty_c = (kind == ffsa_pkg::KIND_ALLOC) && !fhv_q;
	assign free_bad_c = (kind == ffsa_pkg::KIND_FREE) && !free_ok_c;

	// Length of the segment just read (tail segment runs to the pool end)
	assign len_c = (rdata.next_d != '0) ? LW'(rdata.next_d) :
		LW'(POOL_UNITS) - LW'(cur_q);
	assign seg_bytes_c = {len_c, 2'b00};
	assign fits_c = {{(16-LW){1'b0}}, len_c} >= {1'b0, need_q};

	assign head_case_c = !fhv_q || (head_q > cur_q);
	assign m_needed_c = (hu_q.next_d != '0) && (nfree_q || pmerge_q);
	assign m_addr_c = cur_q + hu_q.next_d;

	// Left neighbor absorbing the freed segment; it also unlinks a free right
	// neighbor, whose list predecessor it must be
	always_comb begin
		merged_p_c = rdata;
		merged_p_c.next_d = (hu_q.next_d != '0) ? rdata.next_d + hu_q.next_d : '0;
		if (nfree_q) begin
			merged_p_c.link       = hn_q.link;
			merged_p_c.link_valid = hn_q.link_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = hu_q;
		unique case (state_q)
			ffsa_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				wr_data.start = (clr_q == '0);
				if (clr_q == IW'(POOL_UNITS - 1)) begin
					state_d = reinit_q ? ffsa_pkg::S_DONE : ffsa_pkg::S_IDLE;
				end
			end
			ffsa_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						ffsa_pkg::KIND_ALLOC: begin
							rd_en   = fhv_q;
							rd_addr = head_q;
							state_d = fhv_q ? ffsa_pkg::S_A_CHK : ffsa_pkg::S_DONE;
						end
						ffsa_pkg::KIND_FREE: begin
							rd_en   = free_ok_c;
							rd_addr = IW'(fu_c);
							state_d = free_ok_c ? ffsa_pkg::S_F_CHK : ffsa_pkg::S_DONE;
						end
						ffsa_pkg::KIND_QUERY: begin
							rd_en   = fhv_q;
							rd_addr = head_q;
							state_d = fhv_q ? ffsa_pkg::S_Q_WALK : ffsa_pkg::S_DONE;
						end
						default: begin
							state_d = ffsa_pkg::S_CLEAR;
						end
					endcase
				end
			end
			ffsa_pkg::S_A_CHK: begin
				if (fits_c) begin
					state_d = ffsa_pkg::S_A_FIX;
				end else if (rdata.link_valid) begin
					rd_en   = 1'b1;
					rd_addr = rdata.link;
				end else begin
					state_d = ffsa_pkg::S_DONE;
				end
			end
			ffsa_pkg::S_A_FIX: begin
				// unlink the chosen segment; the split remainder takes its place
				wr_en   = pv_q;
				wr_addr = pred_q;
				wr_data = hpred_q;
				wr_data.link       = split_q ? w_q : hu_q.link;
				wr_data.link_valid = split_q ? 1'b1 : hu_q.link_valid;
				state_d = split_q ? ffsa_pkg::S_A_WW : ffsa_pkg::S_A_WU;
			end
			ffsa_pkg::S_A_WW: begin
				wr_en   = 1'b1;
				wr_addr = w_q;
				wr_data = '0;
				wr_data.start      = 1'b1;
				wr_data.prev_d     = IW'(need_q);
				wr_data.next_d     = (hu_q.next_d != '0) ? hu_q.next_d - IW'(need_q) : '0;
				wr_data.link       = hu_q.link;
				wr_data.link_valid = hu_q.link_valid;
				if (hu_q.next_d != '0) begin
					rd_en   = 1'b1;
					rd_addr = cur_q + hu_q.next_d;
					state_d = ffsa_pkg::S_A_WM;
				end else begin
					state_d = ffsa_pkg::S_A_WU;
				end
			end
			ffsa_pkg::S_A_WM: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = rdata;
				wr_data.prev_d = hu_q.next_d - IW'(need_q);
				state_d = ffsa_pkg::S_A_WU;
			end
			ffsa_pkg::S_A_WU: begin
				wr_en   = 1'b1;
				wr_data = hu_q;
				wr_data.used   = 1'b1;
				wr_data.next_d = split_q ? IW'(need_q) : hu_q.next_d;
				state_d = ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_F_CHK: begin
				if (!(rdata.start && rdata.used)) begin
					state_d = ffsa_pkg::S_DONE;
				end else if (rdata.next_d != '0) begin
					rd_en   = 1'b1;
					rd_addr = cur_q + rdata.next_d;
					state_d = ffsa_pkg::S_F_NCHK;
				end else begin
					state_d = ffsa_pkg::S_F_PREV;
				end
			end
			ffsa_pkg::S_F_NCHK: begin
				state_d = rdata.used ? ffsa_pkg::S_F_PREV : ffsa_pkg::S_F_NCLR;
			end
			ffsa_pkg::S_F_NCLR: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = '0;
				state_d = ffsa_pkg::S_F_PREV;
			end
			ffsa_pkg::S_F_PREV: begin
				if (hu_q.prev_d != '0) begin
					rd_en   = 1'b1;
					rd_addr = cur_q - hu_q.prev_d;
					state_d = ffsa_pkg::S_F_PCHK;
				end else begin
					state_d = ffsa_pkg::S_F_INS;
				end
			end
			ffsa_pkg::S_F_PCHK: begin
				if (!rdata.used) begin
					wr_en   = 1'b1;
					wr_addr = p_q;
					wr_data = merged_p_c;
					state_d = ffsa_pkg::S_F_CLRU;
				end else begin
					state_d = ffsa_pkg::S_F_INS;
				end
			end
			ffsa_pkg::S_F_INS: begin
				if (head_case_c) begin
					state_d = ffsa_pkg::S_F_WU;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					state_d = ffsa_pkg::S_F_WALK;
				end
			end
			ffsa_pkg::S_F_WALK: begin
				if (rdata.link_valid && (rdata.link < cur_q)) begin
					rd_en   = 1'b1;
					rd_addr = rdata.link;
				end else begin
					wr_en   = 1'b1;
					wr_addr = pred_q;
					wr_data = rdata;
					wr_data.link       = cur_q;
					wr_data.link_valid = 1'b1;
					state_d = ffsa_pkg::S_F_WU;
				end
			end
			ffsa_pkg::S_F_CLRU: begin
				wr_en   = 1'b1;
				wr_data = '0;
				state_d = ffsa_pkg::S_F_M;
			end
			ffsa_pkg::S_F_WU: begin
				wr_en   = 1'b1;
				wr_data = hu_q;
				wr_data.used = 1'b0;
				state_d = ffsa_pkg::S_F_M;
			end
			ffsa_pkg::S_F_M: begin
				rd_en   = m_needed_c;
				rd_addr = m_addr_c;
				state_d = m_needed_c ? ffsa_pkg::S_F_WM : ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_F_WM: begin
				wr_en   = 1'b1;
				wr_addr = m_addr_c;
				wr_data = rdata;
				wr_data.prev_d = pmerge_q ? hpred_q.next_d : hu_q.next_d;
				state_d = ffsa_pkg::S_DONE;
			end
			ffsa_pkg::S_Q_WALK: begin
				if (rdata.link_valid) begin
					rd_en   = 1'b1;
					rd_addr = rdata.link;
				end else begin
					state_d = ffsa_pkg::S_DONE;
				end
			end
			ffsa_pkg::S_DONE: begin
				if (out_load_c) begin
					state_d = ffsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffsa_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fhv_q       <= 1'b1;
			alert_en_q  <= 1'b0;
			clr_q       <= '0;
			reinit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				alert_en_q <= cfg_data;
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ffsa_pkg::S_CLEAR: begin
					clr_q <= (clr_q == IW'(POOL_UNITS - 1)) ? '0 : clr_q + 1'b1;
					if (clr_q == IW'(POOL_UNITS - 1)) begin
						head_q <= '0;
						fhv_q  <= 1'b1;
					end
				end
				ffsa_pkg::S_IDLE: begin
					reinit_q <= in_valid && (kind == ffsa_pkg::KIND_REINIT);
				end
				ffsa_pkg::S_A_FIX: begin
					if (!pv_q) begin
						head_q <= split_q ? w_q : hu_q.link;
						fhv_q  <= split_q ? 1'b1 : hu_q.link_valid;
					end
				end
				ffsa_pkg::S_F_INS: begin
					if (head_case_c) begin
						head_q <= cur_q;
						fhv_q  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffsa_pkg::S_IDLE: begin
				pv_q         <= 1'b0;
				nfree_q      <= 1'b0;
				pmerge_q     <= 1'b0;
				need_q       <= need_c;
				fb_q         <= '0;
				lg_q         <= '0;
				cnt_q        <= '0;
				rs_granted_q <= '0;
				cur_q        <= (kind == ffsa_pkg::KIND_FREE) ? IW'(fu_c) : head_q;
				// empty list fails at once; a bad offset is ignored at once
				rs_status_q  <= alloc_empty_c ? ffsa_pkg::STATUS_FAILED :
					free_bad_c ? ffsa_pkg::STATUS_IGNORED : ffsa_pkg::STATUS_DONE;
				rs_alert_q   <= alloc_empty_c && alert_en_q;
				rs_rounded_q <= (alloc_empty_c && alert_en_q) ? {need_c, 2'b00} : '0;
			end
			ffsa_pkg::S_A_CHK: begin
				if (fits_c) begin
					hu_q    <= rdata;
					split_q <= {{(16-LW){1'b0}}, len_c} > ({1'b0, need_q} + 16'd1);
					w_q     <= cur_q + IW'(need_q);
				end else if (rdata.link_valid) begin
					pv_q    <= 1'b1;
					pred_q  <= cur_q;
					hpred_q <= rdata;
					cur_q   <= rdata.link;
				end else begin
					rs_status_q  <= ffsa_pkg::STATUS_FAILED;
					rs_alert_q   <= alert_en_q;
					rs_rounded_q <= alert_en_q ? {need_q, 2'b00} : '0;
				end
			end
			ffsa_pkg::S_A_WW: begin
				n_q <= cur_q + hu_q.next_d;
			end
			ffsa_pkg::S_A_WU: begin
				rs_granted_q <= 12'({(IW+1)'(cur_q) + 1'b1, 2'b00});
			end
			ffsa_pkg::S_F_CHK: begin
				hu_q <= rdata;
				n_q  <= cur_q + rdata.next_d;
				if (!(rdata.start && rdata.used)) begin
					rs_status_q <= ffsa_pkg::STATUS_IGNORED;
				end
			end
			ffsa_pkg::S_F_NCHK: begin
				hn_q <= rdata;
				if (!rdata.used) begin
					nfree_q     <= 1'b1;
					hu_q.next_d <= (rdata.next_d != '0) ? hu_q.next_d + rdata.next_d : '0;
				end
			end
			ffsa_pkg::S_F_PREV: begin
				p_q <= cur_q - hu_q.prev_d;
			end
			ffsa_pkg::S_F_PCHK: begin
				if (!rdata.used) begin
					pmerge_q <= 1'b1;
					hpred_q  <= merged_p_c;
				end
			end
			ffsa_pkg::S_F_INS: begin
				if (head_case_c) begin
					hu_q <= set_link(hu_q, nfree_q ? hn_q.link : head_q,
						nfree_q ? hn_q.link_valid : fhv_q);
				end else begin
					pred_q <= head_q;
				end
			end
			ffsa_pkg::S_F_WALK: begin
				if (rdata.link_valid && (rdata.link < cur_q)) begin
					pred_q <= rdata.link;
				end else begin
					hu_q <= set_link(hu_q, nfree_q ? hn_q.link : rdata.link,
						nfree_q ? hn_q.link_valid : rdata.link_valid);
				end
			end
			ffsa_pkg::S_Q_WALK: begin
				fb_q  <= fb_q + 13'(seg_bytes_c);
				cnt_q <= cnt_q + 11'd1;
				if (seg_bytes_c > lg_q) begin
					lg_q <= seg_bytes_c;
				end
				cur_q <= rdata.link;
			end
			ffsa_pkg::S_DONE: begin
				if (out_load_c) begin
					status_q     <= rs_status_q;
					granted_q    <= rs_granted_q;
					alert_q      <= rs_alert_q;
					rounded_q    <= rs_rounded_q;
					free_bytes_q <= fb_q;
					largest_q    <= 13'(lg_q);
					segs_q       <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign granted_offset = granted_q;
	assign alert          = alert_q;
	assign rounded_bytes  = rounded_q;
	assign free_bytes     = free_bytes_q;
	assign largest_free   = largest_q;
	assign free_segments  = segs_q;

endmodule

// ----- rtl/ffsa_checker.sv -----
module ffsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [11:0] granted_offset,
	input logic        alert,
	input logic [16:0] rounded_bytes,
	input logic [12:0] free_bytes
);

	// stalled result keeps out_valid, status and granted_offset
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_offset))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffsa_pkg::STATUS_DONE |-> granted_offset == 12'd0 &&
		free_bytes == 13'd0)
		else $error("failed transaction carries data");

	a_alert_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alert |-> status == ffsa_pkg::STATUS_FAILED &&
		rounded_bytes != 17'd0)
		else $error("alert without failed allocation");

	a_no_alert_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !alert |-> rounded_bytes == 17'd0)
		else $error("rounded size without alert");

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.granted_offset(granted_offset),
	.alert         (alert),
	.rounded_bytes (rounded_bytes),
	.free_bytes    (free_bytes)
);
